// ===== rtl/core/cfpb_pkg.sv =====
`default_nettype none

package cfpb_pkg;

  localparam int LIMIT_W = 32;
  localparam int TYPE_W  = 2;

  typedef enum logic [TYPE_W-1:0] {
    MODE_RADIUS      = 2'd0,
    MODE_DIAMETER    = 2'd1,
    MODE_ENDPOINTS   = 2'd2,
    MODE_THREE_POINT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_COLLINEAR = 2'd1,
    ST_NEG_RAD   = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/core/circle_from_points_builder.sv =====
`default_nettype none

// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tuser: req_type; tdata: ax ay bx by cx cy length
// m_axis   out  m_axis_tvalid/m_axis_tready  tuser: status; tdata: center_x center_y radius_out
// cfg      in   cfg_valid_i/cfg_ready_o      cfg_data_i: collinear_limit
//
// One word per cycle in and out while the output skid stage is empty.
// The pipeline is made of the divider and the square root, each a COORD_WIDTH+1 stage
// restoring pipeline producing one bit per stage, plus nine multiply and setup stages,
// three clamp, square and saturate stages and one output stage.
// Reset clears valid bits and collinear_limit; data registers are not reset.
// The output has a skid stage; the pipeline halts only while that stage is full.

module circle_from_points_builder #(
  parameter int COORD_WIDTH = 32,
  localparam int DIW = ((7*COORD_WIDTH+7)/8)*8,
  localparam int DOW = ((3*COORD_WIDTH+7)/8)*8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [DIW-1:0]                s_axis_tdata,  // ax, ay, bx, by, cx, cy, length
  input  logic [cfpb_pkg::TYPE_W-1:0]   s_axis_tuser,  // req_type
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [DOW-1:0]                m_axis_tdata,  // center_x, center_y, radius_out
  output logic [1:0]                    m_axis_tuser,  // status
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cfpb_pkg::LIMIT_W-1:0]  cfg_data_i
);
  import cfpb_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int NW    = 3*W+4;
  localparam int DNW   = 2*W+4;
  localparam int SQW   = 2*W+2;
  localparam int SW0   = TYPE_W + 5*W;
  localparam int SWD   = SW0 + SQW + 5;
  localparam int SWS   = TYPE_W + 2 + 3*W;

  typedef struct packed {
    status_e         st;
    logic [W-1:0]    rad;
    logic [W-1:0]    cy;
    logic [W-1:0]    cx;
  } res_t;

  logic [LIMIT_W-1:0] limit_q;
  logic               ce;

  logic signed [W-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy, in_len;
  logic signed [W:0]   sx, sy, sxr, syr;
  logic [W-1:0]        midx, midy;
  logic [SW0-1:0]      side0;

  logic               f_vld;
  logic [SW0-1:0]     f_side;
  logic [SQW-1:0]     f_su;
  logic               f_coll, f_negx, f_negy, f_bigx, f_bigy;
  logic [NW-1:0]      f_numx, f_numy;
  logic [DNW-1:0]     f_den;

  logic               d_vld;
  logic [SWD-1:0]     d_side;
  logic [W:0]         d_qx, d_qy;

  logic [TYPE_W-1:0]  d_mode;
  logic [W-1:0]       d_len, d_ax, d_ay, d_mx, d_my;
  logic [SQW-1:0]     d_su;
  logic               d_coll, d_negx, d_negy, d_bigx, d_bigy;
  logic [W:0]         lim_q;
  logic               clx, cly;
  logic [W:0]         qmx, qmy;

  logic               p1_vld_q, p2_vld_q, p3_vld_q;
  logic [SW0-1:0]     p1_sd_q, p2_sd_q;
  logic [SQW-1:0]     p1_su_q, p2_su_q;
  logic               p1_coll_q, p2_coll_q, p1_ovf_q, p2_ovf_q;
  logic [W:0]         p1_mx_q, p1_my_q;
  logic signed [W+1:0] p1_qx_q, p1_qy_q;
  logic [SQW-1:0]     p2_mx2_q, p2_my2_q;
  logic signed [W+2:0] p2_sumx_q, p2_sumy_q;
  logic [SWS-1:0]     p3_sd_q;
  logic [SQW-1:0]     p3_rad_q;

  logic [TYPE_W-1:0]  p2_mode;
  logic [W-1:0]       p1_ax, p1_ay, p2_len, p2_ax, p2_ay, p2_mx, p2_my;
  logic [SQW-1:0]     s3;
  logic signed [W+2:0] smax, smin;
  logic [W-1:0]       satx, saty, ctrx, ctry;
  logic               ovf3;

  logic               q_vld;
  logic [SWS-1:0]     q_side;
  logic [W:0]         q_root;
  logic               q_up;
  logic [TYPE_W-1:0]  q_mode;
  logic               q_coll, q_ovf;
  logic [W-1:0]       q_cx, q_cy, q_len;
  logic [W+1:0]       r3;
  res_t               fin;

  res_t               out_q, skid_q;
  logic               out_vld_q, skid_vld_q;
  logic               take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  assign ce            = !skid_vld_q;
  assign s_axis_tready = ce;

  assign in_ax  = s_axis_tdata[0*W +: W];
  assign in_ay  = s_axis_tdata[1*W +: W];
  assign in_bx  = s_axis_tdata[2*W +: W];
  assign in_by  = s_axis_tdata[3*W +: W];
  assign in_cx  = s_axis_tdata[4*W +: W];
  assign in_cy  = s_axis_tdata[5*W +: W];
  assign in_len = s_axis_tdata[6*W +: W];

  // midpoint, half rounded away from zero
  assign sx    = (W+1)'(in_ax) + (W+1)'(in_bx);
  assign sy    = (W+1)'(in_ay) + (W+1)'(in_by);
  assign sxr   = sx + (W+1)'(!sx[W]);
  assign syr   = sy + (W+1)'(!sy[W]);
  assign midx  = sxr[W:1];
  assign midy  = syr[W:1];
  assign side0 = {s_axis_tuser, in_len, in_ax, in_ay, midx, midy};

  cfpb_front #(.W(W), .SW(SW0)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .vld_i   (s_axis_tvalid),
    .limit_i (limit_q),
    .side_i  (side0),
    .ax_i    (in_ax),
    .ay_i    (in_ay),
    .bx_i    (in_bx),
    .by_i    (in_by),
    .cx_i    (in_cx),
    .cy_i    (in_cy),
    .vld_o   (f_vld),
    .side_o  (f_side),
    .su_o    (f_su),
    .coll_o  (f_coll),
    .negx_o  (f_negx),
    .negy_o  (f_negy),
    .bigx_o  (f_bigx),
    .bigy_o  (f_bigy),
    .numx_o  (f_numx),
    .numy_o  (f_numy),
    .den_o   (f_den)
  );

  cfpb_div #(.W(W), .SW(SWD)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ce_i   (ce),
    .vld_i  (f_vld),
    .side_i ({f_side, f_su, f_coll, f_negx, f_negy, f_bigx, f_bigy}),
    .numx_i (f_numx),
    .numy_i (f_numy),
    .den_i  (f_den),
    .vld_o  (d_vld),
    .side_o (d_side),
    .qx_o   (d_qx),
    .qy_o   (d_qy)
  );

  assign {d_mode, d_len, d_ax, d_ay, d_mx, d_my, d_su,
          d_coll, d_negx, d_negy, d_bigx, d_bigy} = d_side;

  // clamp quotient magnitude at 2^W
  assign lim_q = (W+1)'(1) << W;
  assign clx   = d_bigx || (d_qx > lim_q);
  assign cly   = d_bigy || (d_qy > lim_q);
  assign qmx   = clx ? lim_q : d_qx;
  assign qmy   = cly ? lim_q : d_qy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
    end else if (ce) begin
      p1_vld_q <= d_vld;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
    end
  end

  assign p1_ax   = p1_sd_q[3*W +: W];
  assign p1_ay   = p1_sd_q[2*W +: W];
  assign p2_mode = p2_sd_q[SW0-1 -: TYPE_W];
  assign p2_len  = p2_sd_q[4*W +: W];
  assign p2_ax   = p2_sd_q[3*W +: W];
  assign p2_ay   = p2_sd_q[2*W +: W];
  assign p2_mx   = p2_sd_q[1*W +: W];
  assign p2_my   = p2_sd_q[0*W +: W];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      p1_sd_q   <= {d_mode, d_len, d_ax, d_ay, d_mx, d_my};
      p1_su_q   <= d_su;
      p1_coll_q <= d_coll;
      p1_ovf_q  <= clx || cly;
      p1_mx_q   <= qmx;
      p1_my_q   <= qmy;
      p1_qx_q   <= d_negx ? -$signed((W+2)'(qmx)) : $signed((W+2)'(qmx));
      p1_qy_q   <= d_negy ? -$signed((W+2)'(qmy)) : $signed((W+2)'(qmy));

      p2_sd_q   <= p1_sd_q;
      p2_su_q   <= p1_su_q;
      p2_coll_q <= p1_coll_q;
      p2_ovf_q  <= p1_ovf_q;
      p2_mx2_q  <= SQW'(p1_mx_q) * SQW'(p1_mx_q);
      p2_my2_q  <= SQW'(p1_my_q) * SQW'(p1_my_q);
      p2_sumx_q <= $signed((W+3)'($signed(p1_ax))) + (W+3)'(p1_qx_q);
      p2_sumy_q <= $signed((W+3)'($signed(p1_ay))) + (W+3)'(p1_qy_q);

      p3_sd_q   <= {p2_mode, p2_coll_q, ovf3, ctrx, ctry, p2_len};
      p3_rad_q  <= (mode_e'(p2_mode) == MODE_ENDPOINTS) ? p2_su_q : s3;
    end
  end

  assign s3   = p2_mx2_q + p2_my2_q;
  assign smax = (W+3)'({1'b0, {(W-1){1'b1}}});
  assign smin = -smax - (W+3)'(1);

  always_comb begin
    ovf3 = p2_ovf_q;
    if (p2_sumx_q > smax) begin
      satx = W'(smax);
      ovf3 = 1'b1;
    end else if (p2_sumx_q < smin) begin
      satx = W'(smin);
      ovf3 = 1'b1;
    end else begin
      satx = W'(p2_sumx_q);
    end
    if (p2_sumy_q > smax) begin
      saty = W'(smax);
      ovf3 = 1'b1;
    end else if (p2_sumy_q < smin) begin
      saty = W'(smin);
      ovf3 = 1'b1;
    end else begin
      saty = W'(p2_sumy_q);
    end
    unique case (mode_e'(p2_mode))
      MODE_THREE_POINT: begin
        ctrx = p2_coll_q ? '0 : satx;
        ctry = p2_coll_q ? '0 : saty;
      end
      MODE_ENDPOINTS: begin
        ctrx = p2_mx;
        ctry = p2_my;
      end
      default: begin
        ctrx = p2_ax;
        ctry = p2_ay;
      end
    endcase
  end

  cfpb_sqrt #(.W(W), .SW(SWS)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ce_i   (ce),
    .vld_i  (p3_vld_q),
    .side_i (p3_sd_q),
    .rad_i  (p3_rad_q),
    .vld_o  (q_vld),
    .side_o (q_side),
    .root_o (q_root),
    .up_o   (q_up)
  );

  assign {q_mode, q_coll, q_ovf, q_cx, q_cy, q_len} = q_side;
  assign r3 = (W+2)'(q_root) + (W+2)'(q_up);

  always_comb begin
    fin.cx  = q_cx;
    fin.cy  = q_cy;
    fin.rad = '0;
    fin.st  = ST_OK;
    unique case (mode_e'(q_mode))
      MODE_RADIUS: begin
        if (q_len[W-1]) begin
          fin.st = ST_NEG_RAD;
        end else begin
          fin.rad = q_len;
        end
      end
      MODE_DIAMETER: begin
        if (q_len[W-1]) begin
          fin.st = ST_NEG_RAD;
        end else begin
          fin.rad = W'(((W+1)'(q_len) + (W+1)'(1)) >> 1);
        end
      end
      MODE_ENDPOINTS: begin
        fin.rad = W'(((W+2)'(q_root) + (W+2)'(1)) >> 1);
      end
      MODE_THREE_POINT: begin
        if (q_coll) begin
          fin.st = ST_COLLINEAR;
        end else if (r3 > (W+2)'({W{1'b1}})) begin
          fin.rad = '1;
          fin.st  = ST_OVERFLOW;
        end else begin
          fin.rad = W'(r3);
          fin.st  = q_ovf ? ST_OVERFLOW : ST_OK;
        end
      end
      default: begin
        fin.st = ST_OK;
      end
    endcase
  end

  assign take = q_vld && ce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || m_axis_tready) begin
        out_vld_q  <= skid_vld_q || take;
        skid_vld_q <= 1'b0;
      end else if (take) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) begin
      out_q <= skid_vld_q ? skid_q : fin;
    end else if (take) begin
      skid_q <= fin;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = DOW'({out_q.rad, out_q.cy, out_q.cx});
  assign m_axis_tuser  = out_q.st;

endmodule

`default_nettype wire

// ===== rtl/core/cfpb_front.sv =====
`default_nettype none

module cfpb_front #(
  parameter int W  = 32,
  parameter int SW = 8,
  localparam int NW  = 3*W+4,
  localparam int DNW = 2*W+4,
  localparam int SQW = 2*W+2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            ce_i,
  input  logic                            vld_i,
  input  logic [cfpb_pkg::LIMIT_W-1:0]    limit_i,
  input  logic [SW-1:0]                   side_i,
  input  logic signed [W-1:0]             ax_i,
  input  logic signed [W-1:0]             ay_i,
  input  logic signed [W-1:0]             bx_i,
  input  logic signed [W-1:0]             by_i,
  input  logic signed [W-1:0]             cx_i,
  input  logic signed [W-1:0]             cy_i,
  output logic                            vld_o,
  output logic [SW-1:0]                   side_o,
  output logic [SQW-1:0]                  su_o,
  output logic                            coll_o,
  output logic                            negx_o,
  output logic                            negy_o,
  output logic                            bigx_o,
  output logic                            bigy_o,
  output logic [NW-1:0]                   numx_o,
  output logic [NW-1:0]                   numy_o,
  output logic [DNW-1:0]                  den_o
);
  import cfpb_pkg::*;

  localparam int DW   = W+1;
  localparam int PW   = 2*W+2;
  localparam int DETW = 2*W+4;
  localparam int HW   = W+1;
  localparam int PPW  = 2*W+3;
  localparam int DVW  = 3*W+5;
  localparam int NST  = 9;

  logic [NST-1:0] vld_q;
  logic [SW-1:0]  sd_q [NST];

  logic signed [DW-1:0]   ux1_q, uy1_q, vx1_q, vy1_q;
  logic signed [DW-1:0]   ux2_q, uy2_q, vx2_q, vy2_q;
  logic signed [PW-1:0]   puv2_q, pyx2_q, qux2_q, quy2_q, qvx2_q, qvy2_q;
  logic signed [DW-1:0]   ux3_q, uy3_q, vx3_q, vy3_q;
  logic signed [DETW-1:0] det3_q;
  logic [SQW-1:0]         su3_q, sv3_q;
  logic [SQW-1:0]         su4_q, su5_q, su6_q, su7_q, su8_q, su9_q;
  logic [DETW-1:0]        absd4_q, absd5_q, absd6_q, absd7_q;
  logic                   dneg4_q, dneg5_q, dneg6_q;
  logic signed [PPW-1:0]  pa_lo_q, pa_hi_q, pb_lo_q, pb_hi_q;
  logic signed [PPW-1:0]  pc_lo_q, pc_hi_q, pd_lo_q, pd_hi_q;
  logic signed [NW-1:0]   a1_q, a2_q, a3_q, a4_q;
  logic                   coll5_q, coll6_q, coll7_q, coll8_q, coll9_q;
  logic signed [NW-1:0]   nx6_q, ny6_q;
  logic [NW-1:0]          anx7_q, any7_q;
  logic                   negx7_q, negy7_q, negx8_q, negy8_q, negx9_q, negy9_q;
  logic [NW-1:0]          numx8_q, numy8_q, numx9_q, numy9_q;
  logic [DNW-1:0]         den8_q, den9_q;
  logic                   bigx9_q, bigy9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[NST-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      sd_q[0] <= side_i;
      for (int i = 1; i < NST; i++) begin
        sd_q[i] <= sd_q[i-1];
      end

      ux1_q <= DW'(bx_i) - DW'(ax_i);
      uy1_q <= DW'(by_i) - DW'(ay_i);
      vx1_q <= DW'(cx_i) - DW'(ax_i);
      vy1_q <= DW'(cy_i) - DW'(ay_i);

      ux2_q  <= ux1_q;
      uy2_q  <= uy1_q;
      vx2_q  <= vx1_q;
      vy2_q  <= vy1_q;
      puv2_q <= ux1_q * vy1_q;
      pyx2_q <= uy1_q * vx1_q;
      qux2_q <= ux1_q * ux1_q;
      quy2_q <= uy1_q * uy1_q;
      qvx2_q <= vx1_q * vx1_q;
      qvy2_q <= vy1_q * vy1_q;

      ux3_q  <= ux2_q;
      uy3_q  <= uy2_q;
      vx3_q  <= vx2_q;
      vy3_q  <= vy2_q;
      det3_q <= (DETW'(puv2_q) - DETW'(pyx2_q)) <<< 1;
      su3_q  <= SQW'(qux2_q) + SQW'(quy2_q);
      sv3_q  <= SQW'(qvx2_q) + SQW'(qvy2_q);

      su4_q   <= su3_q;
      absd4_q <= det3_q[DETW-1] ? DETW'(-det3_q) : DETW'(det3_q);
      dneg4_q <= det3_q[DETW-1];
      pa_lo_q <= vy3_q * $signed({1'b0, su3_q[HW-1:0]});
      pa_hi_q <= vy3_q * $signed({1'b0, su3_q[SQW-1:HW]});
      pb_lo_q <= uy3_q * $signed({1'b0, sv3_q[HW-1:0]});
      pb_hi_q <= uy3_q * $signed({1'b0, sv3_q[SQW-1:HW]});
      pc_lo_q <= ux3_q * $signed({1'b0, sv3_q[HW-1:0]});
      pc_hi_q <= ux3_q * $signed({1'b0, sv3_q[SQW-1:HW]});
      pd_lo_q <= vx3_q * $signed({1'b0, su3_q[HW-1:0]});
      pd_hi_q <= vx3_q * $signed({1'b0, su3_q[SQW-1:HW]});

      su5_q   <= su4_q;
      absd5_q <= absd4_q;
      dneg5_q <= dneg4_q;
      coll5_q <= absd4_q <= DETW'(limit_i);
      a1_q    <= $signed({pa_hi_q, {HW{1'b0}}}) + NW'(pa_lo_q);
      a2_q    <= $signed({pb_hi_q, {HW{1'b0}}}) + NW'(pb_lo_q);
      a3_q    <= $signed({pc_hi_q, {HW{1'b0}}}) + NW'(pc_lo_q);
      a4_q    <= $signed({pd_hi_q, {HW{1'b0}}}) + NW'(pd_lo_q);

      su6_q   <= su5_q;
      absd6_q <= absd5_q;
      dneg6_q <= dneg5_q;
      coll6_q <= coll5_q;
      nx6_q   <= a1_q - a2_q;
      ny6_q   <= a3_q - a4_q;

      su7_q   <= su6_q;
      absd7_q <= absd6_q;
      coll7_q <= coll6_q;
      anx7_q  <= nx6_q[NW-1] ? NW'(-nx6_q) : NW'(nx6_q);
      any7_q  <= ny6_q[NW-1] ? NW'(-ny6_q) : NW'(ny6_q);
      negx7_q <= nx6_q[NW-1] ^ dneg6_q;
      negy7_q <= ny6_q[NW-1] ^ dneg6_q;

      su8_q   <= su7_q;
      coll8_q <= coll7_q;
      negx8_q <= negx7_q;
      negy8_q <= negy7_q;
      numx8_q <= (anx7_q << 1) + NW'(absd7_q);
      numy8_q <= (any7_q << 1) + NW'(absd7_q);
      den8_q  <= DNW'(absd7_q) << 1;

      su9_q   <= su8_q;
      coll9_q <= coll8_q;
      negx9_q <= negx8_q;
      negy9_q <= negy8_q;
      numx9_q <= numx8_q;
      numy9_q <= numy8_q;
      den9_q  <= den8_q;
      bigx9_q <= DVW'(numx8_q) >= (DVW'(den8_q) << (W+1));
      bigy9_q <= DVW'(numy8_q) >= (DVW'(den8_q) << (W+1));
    end
  end

  assign vld_o  = vld_q[NST-1];
  assign side_o = sd_q[NST-1];
  assign su_o   = su9_q;
  assign coll_o = coll9_q;
  assign negx_o = negx9_q;
  assign negy_o = negy9_q;
  assign bigx_o = bigx9_q;
  assign bigy_o = bigy9_q;
  assign numx_o = numx9_q;
  assign numy_o = numy9_q;
  assign den_o  = den9_q;

endmodule

`default_nettype wire

// ===== rtl/core/cfpb_div.sv =====
`default_nettype none

module cfpb_div #(
  parameter int W  = 32,
  parameter int SW = 8,
  localparam int NW  = 3*W+4,
  localparam int DNW = 2*W+4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           ce_i,
  input  logic           vld_i,
  input  logic [SW-1:0]  side_i,
  input  logic [NW-1:0]  numx_i,
  input  logic [NW-1:0]  numy_i,
  input  logic [DNW-1:0] den_i,
  output logic           vld_o,
  output logic [SW-1:0]  side_o,
  output logic [W:0]     qx_o,
  output logic [W:0]     qy_o
);

  localparam int DVW = 3*W+5;
  localparam int NST = W+1;

  logic [NST-1:0] vld_q;
  logic [SW-1:0]  sd_q   [NST];
  logic [DVW-1:0] rx_q   [NST];
  logic [DVW-1:0] ry_q   [NST];
  logic [DVW-1:0] dv_q   [NST];
  logic [W:0]     qx_q   [NST];
  logic [W:0]     qy_q   [NST];

  logic [DVW-1:0] rx_s   [NST];
  logic [DVW-1:0] ry_s   [NST];
  logic [DVW-1:0] dv_s   [NST];
  logic [W:0]     qx_s   [NST];
  logic [W:0]     qy_s   [NST];
  logic [SW-1:0]  sd_s   [NST];
  logic [DVW-1:0] rx_d   [NST];
  logic [DVW-1:0] ry_d   [NST];
  logic [W:0]     qx_d   [NST];
  logic [W:0]     qy_d   [NST];
  logic [DVW-1:0] trial  [NST];

  always_comb begin
    rx_s[0] = DVW'(numx_i);
    ry_s[0] = DVW'(numy_i);
    dv_s[0] = DVW'(den_i);
    qx_s[0] = '0;
    qy_s[0] = '0;
    sd_s[0] = side_i;
    for (int i = 1; i < NST; i++) begin
      rx_s[i] = rx_q[i-1];
      ry_s[i] = ry_q[i-1];
      dv_s[i] = dv_q[i-1];
      qx_s[i] = qx_q[i-1];
      qy_s[i] = qy_q[i-1];
      sd_s[i] = sd_q[i-1];
    end
    for (int i = 0; i < NST; i++) begin
      trial[i] = dv_s[i] << (W-i);
      if (rx_s[i] >= trial[i]) begin
        rx_d[i] = rx_s[i] - trial[i];
        qx_d[i] = qx_s[i] | ((W+1)'(1) << (W-i));
      end else begin
        rx_d[i] = rx_s[i];
        qx_d[i] = qx_s[i];
      end
      if (ry_s[i] >= trial[i]) begin
        ry_d[i] = ry_s[i] - trial[i];
        qy_d[i] = qy_s[i] | ((W+1)'(1) << (W-i));
      end else begin
        ry_d[i] = ry_s[i];
        qy_d[i] = qy_s[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[NST-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int i = 0; i < NST; i++) begin
        rx_q[i] <= rx_d[i];
        ry_q[i] <= ry_d[i];
        dv_q[i] <= dv_s[i];
        qx_q[i] <= qx_d[i];
        qy_q[i] <= qy_d[i];
        sd_q[i] <= sd_s[i];
      end
    end
  end

  assign vld_o  = vld_q[NST-1];
  assign side_o = sd_q[NST-1];
  assign qx_o   = qx_q[NST-1];
  assign qy_o   = qy_q[NST-1];

endmodule

`default_nettype wire

// ===== rtl/core/cfpb_sqrt.sv =====
`default_nettype none

module cfpb_sqrt #(
  parameter int W  = 32,
  parameter int SW = 8,
  localparam int RW = 2*W+2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ce_i,
  input  logic          vld_i,
  input  logic [SW-1:0] side_i,
  input  logic [RW-1:0] rad_i,
  output logic          vld_o,
  output logic [SW-1:0] side_o,
  output logic [W:0]    root_o,
  output logic          up_o
);

  localparam int TW  = RW+1;
  localparam int NST = W+1;

  logic [NST-1:0] vld_q;
  logic [SW-1:0]  sd_q  [NST];
  logic [RW-1:0]  rem_q [NST];
  logic [W:0]     rt_q  [NST];

  logic [SW-1:0]  sd_s  [NST];
  logic [RW-1:0]  rem_s [NST];
  logic [W:0]     rt_s  [NST];
  logic [RW-1:0]  rem_d [NST];
  logic [W:0]     rt_d  [NST];
  logic [TW-1:0]  trial [NST];

  always_comb begin
    sd_s[0]  = side_i;
    rem_s[0] = rad_i;
    rt_s[0]  = '0;
    for (int i = 1; i < NST; i++) begin
      sd_s[i]  = sd_q[i-1];
      rem_s[i] = rem_q[i-1];
      rt_s[i]  = rt_q[i-1];
    end
    for (int i = 0; i < NST; i++) begin
      trial[i] = (TW'(rt_s[i]) << (W-i+1)) + (TW'(1) << (2*(W-i)));
      if (TW'(rem_s[i]) >= trial[i]) begin
        rem_d[i] = rem_s[i] - trial[i][RW-1:0];
        rt_d[i]  = rt_s[i] | ((W+1)'(1) << (W-i));
      end else begin
        rem_d[i] = rem_s[i];
        rt_d[i]  = rt_s[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[NST-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int i = 0; i < NST; i++) begin
        sd_q[i]  <= sd_s[i];
        rem_q[i] <= rem_d[i];
        rt_q[i]  <= rt_d[i];
      end
    end
  end

  assign vld_o  = vld_q[NST-1];
  assign side_o = sd_q[NST-1];
  assign root_o = rt_q[NST-1];
  assign up_o   = rem_q[NST-1] > RW'(rt_q[NST-1]);

endmodule

`default_nettype wire
